// ----- rtl/mss_pkg.sv -----
`default_nettype none

package mss_pkg;

    // Default geometry
    localparam int COORD_BITS_DEF     = 16;
    localparam int TIME_FRAC_BITS_DEF = 16;

    // Fixed port widths
    localparam int CENTER_W  = 48;
    localparam int RADIUS_W  = 16;
    localparam int TIME_W    = 32;
    localparam int OUTCOME_W = 3;

    // Depth of the queues between front, back and result port
    localparam int FIFO_DEPTH = 4;

    // Outcome codes
    localparam logic [OUTCOME_W-1:0] OC_OVERLAP   = 3'd0;
    localparam logic [OUTCOME_W-1:0] OC_NO_MOTION = 3'd1;
    localparam logic [OUTCOME_W-1:0] OC_APART     = 3'd2;
    localparam logic [OUTCOME_W-1:0] OC_NO_ROOT   = 3'd3;
    localparam logic [OUTCOME_W-1:0] OC_CONTACT   = 3'd4;

    // Queue status seen by the neighbours
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

`default_nettype wire

// ----- rtl/mss_fifo.sv -----
`default_nettype none

module mss_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mss_pkg::FIFO_DEPTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire logic [WIDTH-1:0]    i_data,
    input  wire logic                i_pop,
    output logic [WIDTH-1:0]         o_data,
    output mss_pkg::t_fifo_stat      o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign push_ok      = i_push && !o_stat.full;
    assign pop_ok       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    // Advance pointers, wrapping at the depth
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push_ok) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (pop_ok) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + CW'(1);
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store the incoming request
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mss_front.sv -----
`default_nettype none

module mss_front #(
    parameter int COORD_BITS = mss_pkg::COORD_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire logic [mss_pkg::CENTER_W-1:0]      i_first_center,
    input  wire logic [mss_pkg::RADIUS_W-1:0]      i_first_radius,
    input  wire logic [mss_pkg::CENTER_W-1:0]      i_second_center,
    input  wire logic [mss_pkg::RADIUS_W-1:0]      i_second_radius,
    input  wire logic [mss_pkg::CENTER_W-1:0]      i_first_motion,
    input  wire logic [mss_pkg::CENTER_W-1:0]      i_second_motion,
    output logic                                   o_valid,
    output logic [mss_pkg::OUTCOME_W-1:0]          o_outcome,
    output logic [4*COORD_BITS+3:0]                o_disc,
    output logic [2*COORD_BITS+1:0]                o_nb,
    output logic [2*COORD_BITS+1:0]                o_a
);

    localparam int C    = COORD_BITS;
    localparam int S_W  = C + 1;
    localparam int P_W  = 2 * C + 2;
    localparam int B_W  = 2 * C + 3;
    localparam int C_W  = 2 * C + 4;
    localparam int H    = C + 1;
    localparam int X_W  = 2 * H;
    localparam int D_W  = 4 * H;
    localparam int PK_W = (3 * C > mss_pkg::CENTER_W) ? 3 * C : mss_pkg::CENTER_W;

    logic [PK_W-1:0] c0_ext, c1_ext, m0_ext, m1_ext;
    logic [C-1:0]    rad0, rad1;

    // Stage 1: differences
    logic                  r_v1;
    logic signed [S_W-1:0] r_s [3];
    logic signed [S_W-1:0] r_m [3];
    logic [C:0]            r_r;
    logic signed [S_W-1:0] n_s [3];
    logic signed [S_W-1:0] n_m [3];

    // Stage 2: products
    logic                  r_v2;
    logic signed [P_W-1:0] r_ss [3];
    logic signed [P_W-1:0] r_vv [3];
    logic signed [P_W-1:0] r_vs [3];
    logic [P_W-1:0]        r_rr;

    // Stage 3: dot products
    logic                  r_v3;
    logic [P_W-1:0]        r_a;
    logic signed [B_W-1:0] r_b;
    logic signed [C_W-1:0] r_c;
    logic [P_W-1:0]        n_ssum;

    // Stage 4: classification and partial products
    logic                          r_v4;
    logic [mss_pkg::OUTCOME_W-1:0] r_oc4;
    logic [X_W-1:0]                r_nb4, r_a4;
    logic [X_W-1:0]                r_bll, r_blh, r_bhh;
    logic [X_W-1:0]                r_all, r_alh, r_ahl, r_ahh;
    logic [mss_pkg::OUTCOME_W-1:0] n_oc4;
    logic [X_W-1:0]                n_nb, n_cu;

    // Stage 5: discriminant
    logic                          r_v5;
    logic [mss_pkg::OUTCOME_W-1:0] r_oc5;
    logic [D_W-1:0]                r_disc;
    logic [X_W-1:0]                r_nb5, r_a5;
    logic [D_W-1:0]                n_bb, n_ac;

    assign c0_ext = PK_W'(i_first_center);
    assign c1_ext = PK_W'(i_second_center);
    assign m0_ext = PK_W'(i_first_motion);
    assign m1_ext = PK_W'(i_second_motion);
    assign rad0   = C'(i_first_radius);
    assign rad1   = C'(i_second_radius);

    // Unpack coordinates and take differences
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s[i] = S_W'($signed(c1_ext[i*C +: C])) - S_W'($signed(c0_ext[i*C +: C]));
            n_m[i] = S_W'($signed(m1_ext[i*C +: C])) - S_W'($signed(m0_ext[i*C +: C]));
        end
    end

    // Sum the products and classify
    always_comb begin
        n_ssum = $unsigned(r_ss[0]) + $unsigned(r_ss[1]) + $unsigned(r_ss[2]);
        n_nb   = X_W'(-r_b);
        n_cu   = r_c[X_W-1:0];
        if (r_c < 0) begin
            n_oc4 = mss_pkg::OC_OVERLAP;
        end else if (r_a == '0) begin
            n_oc4 = mss_pkg::OC_NO_MOTION;
        end else if (r_b >= 0) begin
            n_oc4 = mss_pkg::OC_APART;
        end else begin
            n_oc4 = mss_pkg::OC_CONTACT;
        end
    end

    // Recombine partial products into b*b and a*c
    always_comb begin
        n_bb = (D_W'(r_bhh) << (2 * H)) + (D_W'(r_blh) << (H + 1)) + D_W'(r_bll);
        n_ac = (D_W'(r_ahh) << (2 * H)) + ((D_W'(r_alh) + D_W'(r_ahl)) << H)
             + D_W'(r_all);
    end

    // Advance valid flags while the queue has room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s[i]  <= n_s[i];
                r_m[i]  <= n_m[i];
                r_ss[i] <= P_W'(r_s[i]) * P_W'(r_s[i]);
                r_vv[i] <= P_W'(r_m[i]) * P_W'(r_m[i]);
                r_vs[i] <= P_W'(r_m[i]) * P_W'(r_s[i]);
            end
            r_r   <= (C + 1)'(rad0) + (C + 1)'(rad1);
            r_rr  <= P_W'(r_r) * P_W'(r_r);

            r_a   <= $unsigned(r_vv[0]) + $unsigned(r_vv[1]) + $unsigned(r_vv[2]);
            r_b   <= B_W'(r_vs[0]) + B_W'(r_vs[1]) + B_W'(r_vs[2]);
            r_c   <= $signed(C_W'(n_ssum)) - $signed(C_W'(r_rr));

            r_oc4 <= n_oc4;
            r_nb4 <= n_nb;
            r_a4  <= r_a;
            r_bll <= X_W'(n_nb[H-1:0]) * X_W'(n_nb[H-1:0]);
            r_blh <= X_W'(n_nb[H-1:0]) * X_W'(n_nb[X_W-1:H]);
            r_bhh <= X_W'(n_nb[X_W-1:H]) * X_W'(n_nb[X_W-1:H]);
            r_all <= X_W'(r_a[H-1:0]) * X_W'(n_cu[H-1:0]);
            r_alh <= X_W'(r_a[H-1:0]) * X_W'(n_cu[X_W-1:H]);
            r_ahl <= X_W'(r_a[X_W-1:H]) * X_W'(n_cu[H-1:0]);
            r_ahh <= X_W'(r_a[X_W-1:H]) * X_W'(n_cu[X_W-1:H]);

            r_oc5  <= (r_oc4 == mss_pkg::OC_CONTACT && n_ac > n_bb) ?
                      mss_pkg::OC_NO_ROOT : r_oc4;
            r_disc <= n_bb - n_ac;
            r_nb5  <= r_nb4;
            r_a5   <= r_a4;
        end
    end

    assign o_valid   = r_v5;
    assign o_outcome = r_oc5;
    assign o_disc    = r_disc;
    assign o_nb      = r_nb5;
    assign o_a       = r_a5;

endmodule

`default_nettype wire

// ----- rtl/mss_back.sv -----
`default_nettype none

module mss_back #(
    parameter int COORD_BITS     = mss_pkg::COORD_BITS_DEF,
    parameter int TIME_FRAC_BITS = mss_pkg::TIME_FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire logic [mss_pkg::OUTCOME_W-1:0]     i_outcome,
    input  wire logic [4*COORD_BITS+3:0]           i_disc,
    input  wire logic [2*COORD_BITS+1:0]           i_nb,
    input  wire logic [2*COORD_BITS+1:0]           i_a,
    output logic                                   o_valid,
    output logic                                   o_hit,
    output logic [mss_pkg::TIME_W-1:0]             o_time,
    output logic [mss_pkg::OUTCOME_W-1:0]          o_outcome
);

    localparam int QW  = 2 * COORD_BITS + 2;
    localparam int D_W = 2 * QW;
    localparam int F   = TIME_FRAC_BITS;
    localparam int N_W = QW + F;
    localparam int T_W = mss_pkg::TIME_W;

    // Square root pipeline, one root bit a stage
    logic                          r_qv   [QW+1];
    logic [mss_pkg::OUTCOME_W-1:0] r_qoc  [QW+1];
    logic [D_W-1:0]                r_qrem [QW+1];
    logic [QW-1:0]                 r_qq   [QW+1];
    logic [QW-1:0]                 r_qnb  [QW+1];
    logic [QW-1:0]                 r_qa   [QW+1];
    logic [D_W-1:0]                n_qrem [QW+1];
    logic [QW-1:0]                 n_qq   [QW+1];

    // Divider pipeline, one quotient bit a stage
    logic                          r_dv   [N_W+1];
    logic [mss_pkg::OUTCOME_W-1:0] r_doc  [N_W+1];
    logic [QW-1:0]                 r_drem [N_W+1];
    logic [QW-1:0]                 r_dn   [N_W+1];
    logic [QW-1:0]                 r_da   [N_W+1];
    logic [T_W-1:0]                r_dql  [N_W+1];
    logic                          r_dovf [N_W+1];
    logic [QW-1:0]                 n_drem [N_W+1];
    logic [T_W-1:0]                n_dql  [N_W+1];
    logic                          n_dovf [N_W+1];

    logic [mss_pkg::OUTCOME_W-1:0] last_oc;

    // Restoring square root: try each root bit from the top
    always_comb begin
        logic [D_W:0] trial;
        int           bi;
        n_qrem[0] = '0;
        n_qq[0]   = '0;
        for (int k = 0; k < QW; k++) begin
            bi    = QW - 1 - k;
            trial = ({1'b0, D_W'(r_qq[k])} << (bi + 1)) + ((D_W + 1)'(1) << (2 * bi));
            if (trial <= {1'b0, r_qrem[k]}) begin
                n_qrem[k+1] = D_W'({1'b0, r_qrem[k]} - trial);
                n_qq[k+1]   = r_qq[k] | (QW'(1) << bi);
            end else begin
                n_qrem[k+1] = r_qrem[k];
                n_qq[k+1]   = r_qq[k];
            end
        end
    end

    // Restoring division of n shifted up by the fraction bits
    always_comb begin
        logic [QW:0] rsh;
        logic        bit_in;
        logic        ge;
        int          j;
        n_drem[0] = '0;
        n_dql[0]  = '0;
        n_dovf[0] = 1'b0;
        for (int k = 0; k < N_W; k++) begin
            j      = N_W - 1 - k;
            bit_in = 1'b0;
            if (j >= F) begin
                bit_in = r_dn[k][j-F];
            end
            rsh = {r_drem[k], bit_in};
            ge  = (rsh >= {1'b0, r_da[k]});
            n_drem[k+1] = ge ? QW'(rsh - {1'b0, r_da[k]}) : QW'(rsh);
            n_dql[k+1]  = r_dql[k];
            n_dovf[k+1] = r_dovf[k];
            if (ge && j < T_W) begin
                n_dql[k+1][j[4:0]] = 1'b1;
            end
            if (ge && j >= T_W) begin
                n_dovf[k+1] = 1'b1;
            end
        end
    end

    // Advance valid flags while the result queue has room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                r_qv[k] <= 1'b0;
            end
            for (int k = 0; k <= N_W; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_qv[0] <= i_valid;
            for (int k = 0; k < QW; k++) begin
                r_qv[k+1] <= r_qv[k];
            end
            r_dv[0] <= r_qv[QW];
            for (int k = 0; k < N_W; k++) begin
                r_dv[k+1] <= r_dv[k];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qoc[0]  <= i_outcome;
            r_qrem[0] <= i_disc;
            r_qq[0]   <= '0;
            r_qnb[0]  <= i_nb;
            r_qa[0]   <= i_a;
            for (int k = 0; k < QW; k++) begin
                r_qoc[k+1]  <= r_qoc[k];
                r_qrem[k+1] <= n_qrem[k+1];
                r_qq[k+1]   <= n_qq[k+1];
                r_qnb[k+1]  <= r_qnb[k];
                r_qa[k+1]   <= r_qa[k];
            end
            r_doc[0]  <= r_qoc[QW];
            r_drem[0] <= n_drem[0];
            r_dn[0]   <= r_qnb[QW] - r_qq[QW];
            r_da[0]   <= r_qa[QW];
            r_dql[0]  <= n_dql[0];
            r_dovf[0] <= n_dovf[0];
            for (int k = 0; k < N_W; k++) begin
                r_doc[k+1]  <= r_doc[k];
                r_drem[k+1] <= n_drem[k+1];
                r_dn[k+1]   <= r_dn[k];
                r_da[k+1]   <= r_da[k];
                r_dql[k+1]  <= n_dql[k+1];
                r_dovf[k+1] <= n_dovf[k+1];
            end
        end
    end

    // Form the result, saturating the time
    assign last_oc   = r_doc[N_W];
    assign o_valid   = r_dv[N_W];
    assign o_outcome = last_oc;
    assign o_hit     = (last_oc == mss_pkg::OC_OVERLAP) || (last_oc == mss_pkg::OC_CONTACT);
    assign o_time    = (last_oc != mss_pkg::OC_CONTACT) ? '0 :
                       (r_dovf[N_W] ? '1 : r_dql[N_W]);

endmodule

`default_nettype wire

// ----- rtl/moving_sphere_sphere_test.sv -----
// Moving sphere against moving sphere contact test.
// Input channel: present both spheres (centres, radii, motions) with push;
// a request is taken on a clock edge where push is high and full is low.
// Result channel: while empty is low the oldest result (hit, contact_time,
// outcome) is on the ports; pop on such an edge takes it.
// One request a cycle is sustained while the receiver keeps popping. From
// acceptance to the result showing, a request passes through
// five front stages that form the dot products and the discriminant, a queue
// stage, then the back pipeline, which resolves one square-root bit a stage
// (2*COORD_BITS+2 stages) and one quotient bit a stage
// (2*COORD_BITS+2+TIME_FRAC_BITS stages), then the result queue.
// Reset empties both queues and clears every pipeline valid; full and
// empty read low and high in the cycle after reset is applied.
// If the receiver stops popping, the result queue fills and the back
// pipeline holds; the front then fills its queue, holds, and raises full.
`default_nettype none

module moving_sphere_sphere_test #(
    parameter int COORD_BITS     = mss_pkg::COORD_BITS_DEF,
    parameter int TIME_FRAC_BITS = mss_pkg::TIME_FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [mss_pkg::CENTER_W-1:0]      i_first_center,
    input  wire logic [mss_pkg::RADIUS_W-1:0]      i_first_radius,
    input  wire logic [mss_pkg::CENTER_W-1:0]      i_second_center,
    input  wire logic [mss_pkg::RADIUS_W-1:0]      i_second_radius,
    input  wire logic [mss_pkg::CENTER_W-1:0]      i_first_motion,
    input  wire logic [mss_pkg::CENTER_W-1:0]      i_second_motion,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic                                   o_hit,
    output logic [mss_pkg::TIME_W-1:0]             o_contact_time,
    output logic [mss_pkg::OUTCOME_W-1:0]          o_outcome
);

    localparam int X_W   = 2 * COORD_BITS + 2;
    localparam int D_W   = 2 * X_W;
    localparam int MID_W = mss_pkg::OUTCOME_W + D_W + 2 * X_W;
    localparam int OUT_W = 1 + mss_pkg::TIME_W + mss_pkg::OUTCOME_W;

    mss_pkg::t_fifo_stat           mid_stat, out_stat;
    logic                          en_front, en_back;
    logic                          f_valid;
    logic [mss_pkg::OUTCOME_W-1:0] f_oc;
    logic [D_W-1:0]                f_disc;
    logic [X_W-1:0]                f_nb, f_a;
    logic [MID_W-1:0]              mid_out;
    logic                          b_valid, b_hit;
    logic [mss_pkg::TIME_W-1:0]    b_time;
    logic [mss_pkg::OUTCOME_W-1:0] b_oc;

    assign en_front = !mid_stat.full;
    assign en_back  = !out_stat.full;
    assign full     = mid_stat.full;
    assign empty    = out_stat.empty;

    // Front: differences, dot products, classification, discriminant
    mss_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en_front),
        .i_valid         (push && !full),
        .i_first_center  (i_first_center),
        .i_first_radius  (i_first_radius),
        .i_second_center (i_second_center),
        .i_second_radius (i_second_radius),
        .i_first_motion  (i_first_motion),
        .i_second_motion (i_second_motion),
        .o_valid         (f_valid),
        .o_outcome       (f_oc),
        .o_disc          (f_disc),
        .o_nb            (f_nb),
        .o_a             (f_a)
    );

    // Decouple front from back
    mss_fifo #(
        .WIDTH (MID_W),
        .DEPTH (mss_pkg::FIFO_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (en_front && f_valid),
        .i_data  ({f_oc, f_disc, f_nb, f_a}),
        .i_pop   (en_back),
        .o_data  (mid_out),
        .o_stat  (mid_stat)
    );

    // Back: square root and division
    mss_back #(
        .COORD_BITS     (COORD_BITS),
        .TIME_FRAC_BITS (TIME_FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en_back),
        .i_valid   (!mid_stat.empty),
        .i_outcome (mid_out[MID_W-1 -: mss_pkg::OUTCOME_W]),
        .i_disc    (mid_out[2*X_W +: D_W]),
        .i_nb      (mid_out[X_W +: X_W]),
        .i_a       (mid_out[X_W-1:0]),
        .o_valid   (b_valid),
        .o_hit     (b_hit),
        .o_time    (b_time),
        .o_outcome (b_oc)
    );

    // Hold results for the receiver
    mss_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (mss_pkg::FIFO_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (en_back && b_valid),
        .i_data  ({b_hit, b_time, b_oc}),
        .i_pop   (pop),
        .o_data  ({o_hit, o_contact_time, o_outcome}),
        .o_stat  (out_stat)
    );

endmodule

`default_nettype wire

// ----- rtl/mss_checker.sv -----
`default_nettype none

module mss_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              full,
    input wire logic                              empty,
    input wire logic                              pop,
    input wire logic                              o_hit,
    input wire logic [mss_pkg::TIME_W-1:0]        o_contact_time,
    input wire logic [mss_pkg::OUTCOME_W-1:0]     o_outcome
);

    // Hit agrees with the outcome code
    a_hit_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_hit == ((o_outcome == mss_pkg::OC_OVERLAP) ||
                              (o_outcome == mss_pkg::OC_CONTACT))))
        else $error("hit disagrees with outcome");

    // Time is zero unless a contact was found
    a_time_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_outcome != mss_pkg::OC_CONTACT) |-> (o_contact_time == '0))
        else $error("nonzero time without contact");

    // Outcome stays within its codes
    a_outcome_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_outcome <= mss_pkg::OC_CONTACT))
        else $error("outcome out of range");

    // A result not taken holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_outcome) && $stable(o_contact_time)))
        else $error("waiting result changed");

    // Reset empties both sides
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

endmodule

bind moving_sphere_sphere_test mss_checker u_mss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_hit          (o_hit),
    .o_contact_time (o_contact_time),
    .o_outcome      (o_outcome)
);

`default_nettype wire

// ----- tb/moving_sphere_sphere_test_tb.sv -----
`timescale 1ns / 1ps

module moving_sphere_sphere_test_tb;

    typedef struct packed {
        logic                          hit;
        logic [mss_pkg::TIME_W-1:0]    ctime;
        logic [mss_pkg::OUTCOME_W-1:0] outcome;
    } t_contact;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          push;
    logic                          full;
    logic [mss_pkg::CENTER_W-1:0]  i_first_center;
    logic [mss_pkg::RADIUS_W-1:0]  i_first_radius;
    logic [mss_pkg::CENTER_W-1:0]  i_second_center;
    logic [mss_pkg::RADIUS_W-1:0]  i_second_radius;
    logic [mss_pkg::CENTER_W-1:0]  i_first_motion;
    logic [mss_pkg::CENTER_W-1:0]  i_second_motion;
    logic                          empty;
    logic                          pop;
    logic                          o_hit;
    logic [mss_pkg::TIME_W-1:0]    o_contact_time;
    logic [mss_pkg::OUTCOME_W-1:0] o_outcome;

    t_contact contact_q[$];
    int       n_errors = 0;
    int       rx_mode = 0;
    int       rx_hold = 0;
    int       rx_cyc = 0;

    moving_sphere_sphere_test u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_first_center (i_first_center),
        .i_first_radius (i_first_radius),
        .i_second_center(i_second_center),
        .i_second_radius(i_second_radius),
        .i_first_motion (i_first_motion),
        .i_second_motion(i_second_motion),
        .empty          (empty),
        .pop            (pop),
        .o_hit          (o_hit),
        .o_contact_time (o_contact_time),
        .o_outcome      (o_outcome)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Work out the contact of one sphere pair in exact integer arithmetic
    function automatic t_contact sweep_contact(input logic [mss_pkg::CENTER_W-1:0] c0,
                                               input logic [mss_pkg::RADIUS_W-1:0] r0,
                                               input logic [mss_pkg::CENTER_W-1:0] c1,
                                               input logic [mss_pkg::RADIUS_W-1:0] r1,
                                               input logic [mss_pkg::CENTER_W-1:0] m0,
                                               input logic [mss_pkg::CENTER_W-1:0] m1);
        longint     s[3];
        longint     v[3];
        longint     rsum, cc, aa, bb;
        logic [127:0] nb, sq_b, prod_ac, disc, root, trial, num, quo;
        int         k;
        t_contact   res;
        for (k = 0; k < 3; k++) begin
            s[k] = longint'($signed(c1[16*k +: 16])) - longint'($signed(c0[16*k +: 16]));
            v[k] = longint'($signed(m1[16*k +: 16])) - longint'($signed(m0[16*k +: 16]));
        end
        rsum = longint'(r0) + longint'(r1);
        cc = s[0]*s[0] + s[1]*s[1] + s[2]*s[2] - rsum*rsum;
        aa = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
        bb = v[0]*s[0] + v[1]*s[1] + v[2]*s[2];
        res = '0;
        if (cc < 0) begin
            res.hit = 1'b1;
            res.outcome = mss_pkg::OC_OVERLAP;
        end else if (aa == 0) begin
            res.outcome = mss_pkg::OC_NO_MOTION;
        end else if (bb >= 0) begin
            res.outcome = mss_pkg::OC_APART;
        end else begin
            nb = 128'(-bb);
            sq_b = nb * nb;
            prod_ac = 128'(aa) * 128'(cc);
            if (prod_ac > sq_b) begin
                res.outcome = mss_pkg::OC_NO_ROOT;
            end else begin
                // floor root, one bit at a time from the top
                disc = sq_b - prod_ac;
                root = '0;
                for (k = 45; k >= 0; k--) begin
                    trial = root | (128'd1 << k);
                    if (trial * trial <= disc) root = trial;
                end
                num = (nb - root) << mss_pkg::TIME_FRAC_BITS_DEF;
                quo = num / 128'(aa);
                res.ctime = (quo > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
                res.hit = 1'b1;
                res.outcome = mss_pkg::OC_CONTACT;
            end
        end
        return res;
    endfunction

    function automatic logic [mss_pkg::CENTER_W-1:0] pack3(input int x, input int y,
                                                           input int z);
        return {z[15:0], y[15:0], x[15:0]};
    endfunction

    // Random signed coordinate of random magnitude
    function automatic int rand_coord();
        int span;
        span = (1 << $urandom_range(0, 15)) - 1;
        return $urandom_range(0, 2*span) - span;
    endfunction

    // Offer one request and hold it until taken; called and returns at a falling edge
    task automatic send_pair(input logic [mss_pkg::CENTER_W-1:0] c0,
                             input logic [mss_pkg::RADIUS_W-1:0] r0,
                             input logic [mss_pkg::CENTER_W-1:0] c1,
                             input logic [mss_pkg::RADIUS_W-1:0] r1,
                             input logic [mss_pkg::CENTER_W-1:0] m0,
                             input logic [mss_pkg::CENTER_W-1:0] m1);
        logic took;
        i_first_center  = c0;
        i_first_radius  = r0;
        i_second_center = c1;
        i_second_radius = r1;
        i_first_motion  = m0;
        i_second_motion = m1;
        push = 1'b1;
        forever begin
            took = !full;
            if (took) begin
                contact_q.insert(contact_q.size(), sweep_contact(c0, r0, c1, r1, m0, m1));
            end
            @(negedge i_clk);
            if (took) break;
        end
    endtask

    task automatic idle_sender(input int cycles);
        push = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic send_random_pair();
        int sx, sy, sz, vx, vy, vz, ox, oy, oz, sh;
        logic [mss_pkg::CENTER_W-1:0] c0, m0;
        if ($urandom_range(0, 7) == 0) begin
            send_pair(mss_pkg::CENTER_W'({$urandom(), $urandom()}),
                      mss_pkg::RADIUS_W'($urandom()),
                      mss_pkg::CENTER_W'({$urandom(), $urandom()}),
                      mss_pkg::RADIUS_W'($urandom()),
                      mss_pkg::CENTER_W'({$urandom(), $urandom()}),
                      mss_pkg::CENTER_W'({$urandom(), $urandom()}));
        end else begin
            // well-formed approach: second sphere moves roughly back along s
            sx = rand_coord(); sy = rand_coord(); sz = rand_coord();
            sh = $urandom_range(0, 4);
            vx = -(sx >>> sh) + $urandom_range(0, 8) - 4;
            vy = -(sy >>> sh) + $urandom_range(0, 8) - 4;
            vz = -(sz >>> sh) + $urandom_range(0, 8) - 4;
            ox = rand_coord(); oy = rand_coord(); oz = rand_coord();
            c0 = pack3(ox, oy, oz);
            m0 = pack3(rand_coord() >>> 2, rand_coord() >>> 2, rand_coord() >>> 2);
            send_pair(c0,
                      mss_pkg::RADIUS_W'($urandom_range(0, 1 << $urandom_range(0, 16))),
                      pack3(ox + sx, oy + sy, oz + sz),
                      mss_pkg::RADIUS_W'($urandom_range(0, 1 << $urandom_range(0, 16))),
                      m0, pack3(int'($signed(m0[15:0])) + vx, int'($signed(m0[31:16])) + vy,
                                int'($signed(m0[47:32])) + vz));
        end
    endtask

    task automatic wait_drained();
        while (contact_q.size() != 0) @(negedge i_clk);
    endtask

    // Receiver: steady pops, random pops, a stall pattern, or a long hold-off
    always @(negedge i_clk) begin
        rx_cyc <= rx_cyc + 1;
        if (rx_hold > 0) begin
            pop = 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            case (rx_mode)
                0: pop = 1'b1;
                1: pop = 1'($urandom_range(0, 1));
                default: pop = (rx_cyc % 11) > 3;
            endcase
        end
    end

    // Compare each popped result with the oldest prediction
    always @(posedge i_clk) begin
        t_contact want;
        if (i_rst_n && pop && !empty) begin
            if (contact_q.size() == 0) begin
                $error("result with no prediction waiting");
                n_errors++;
            end else begin
                want = contact_q.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, o_hit);
                    n_errors++;
                end
                if (o_contact_time !== want.ctime) begin
                    $error("contact_time: expected %h, got %h", want.ctime, o_contact_time);
                    n_errors++;
                end
                if (o_outcome !== want.outcome) begin
                    $error("outcome: expected %0d, got %0d", want.outcome, o_outcome);
                    n_errors++;
                end
            end
        end
    end

    // Field extremes and every outcome
    task automatic test_directed();
        rx_mode = 0;
        send_pair('0, '0, '0, '0, '0, '0);
        send_pair('1, '1, '1, '1, '1, '1);
        send_pair(pack3(0, 0, 0), 16'h0100, pack3(100, 0, 0), 16'h0100, '0, '0);
        send_pair(pack3(0, 0, 0), 16'h0010, pack3(4000, 0, 0), 16'h0010, '0, '0);
        send_pair(pack3(0, 0, 0), 16'h0010, pack3(4000, 0, 0), 16'h0010,
                  pack3(7, 7, 7), pack3(7, 7, 7));
        send_pair(pack3(0, 0, 0), 16'h0010, pack3(4000, 0, 0), 16'h0010,
                  '0, pack3(100, 0, 0));
        send_pair(pack3(0, 0, 0), 16'h0010, pack3(4000, 4000, 0), 16'h0010,
                  '0, pack3(-100, 0, 0));
        send_pair(pack3(0, 0, 0), 16'h0010, pack3(4000, 0, 0), 16'h0010,
                  '0, pack3(-3000, 0, 0));
        send_pair(pack3(0, 0, 0), 16'h0010, pack3(4000, 0, 0), 16'h0010,
                  '0, pack3(-1, 0, 0));
        send_pair(pack3(-32768, -32768, -32768), 16'h0000, pack3(32767, 32767, 32767),
                  16'h0000, pack3(32767, 32767, 32767), pack3(-32768, -32768, -32768));
        send_pair(pack3(32767, 0, 0), 16'hFFFF, pack3(-32768, 0, 0), 16'hFFFF, '0, '0);
        send_pair(pack3(-32768, 0, 0), 16'h0000, pack3(32767, 0, 0), 16'h0000,
                  '0, pack3(-1, 0, 0));
        send_pair(pack3(0, 0, 0), 16'h0000, pack3(50, 0, 0), 16'h0000,
                  '0, pack3(-50, 0, 0));
        send_pair(pack3(0, 0, 0), 16'h0000, pack3(10, 0, 0), 16'h0000,
                  '0, pack3(0, 0, -5));
        send_pair(pack3(0, 0, 0), 16'h8000, pack3(-32768, 0, 0), 16'h8000,
                  pack3(0, 32767, 0), pack3(0, -32768, 0));
        idle_sender(1);
    endtask

    // Bursts with gaps, receiver behaviour changing as it goes
    task automatic test_random();
        int sent, burst;
        sent = 0;
        while (sent < 1300) begin
            rx_mode = (sent / 150) % 3;
            burst = $urandom_range(1, 24);
            repeat (burst) send_random_pair();
            sent += burst;
            idle_sender($urandom_range(0, 6));
        end
    endtask

    // Hold the receiver off long enough for full to rise, sender keeps offering
    task automatic test_backpressure();
        rx_mode = 0;
        rx_hold = 400;
        repeat (150) send_random_pair();
        idle_sender(1);
    endtask

    // Pause until every prediction is met, then resume
    task automatic test_drain_resume();
        rx_mode = 1;
        wait_drained();
        idle_sender(5);
        repeat (30) send_random_pair();
        idle_sender(1);
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_first_center = '0;
        i_first_radius = '0;
        i_second_center = '0;
        i_second_radius = '0;
        i_first_motion = '0;
        i_second_motion = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        test_drain_resume();
        rx_mode = 0;
        wait_drained();
        repeat (200) @(negedge i_clk);
        if (n_errors == 0 && contact_q.size() == 0) begin
            $display("** moving_sphere_sphere_test: PASSED **");
        end else begin
            if (contact_q.size() != 0) $error("%0d predictions never met", contact_q.size());
            $display("** moving_sphere_sphere_test: FAILED **");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("** moving_sphere_sphere_test: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mss_pkg.sv
rtl/mss_fifo.sv
rtl/mss_front.sv
rtl/mss_back.sv
rtl/moving_sphere_sphere_test.sv
rtl/mss_checker.sv
tb/moving_sphere_sphere_test_tb.sv
